@@ rtl/core/likelihood_field_map_defines.svh @@
// Assertion macros used across the likelihood field map RTL.
`ifndef LIKELIHOOD_FIELD_MAP_DEFINES_SVH
`define LIKELIHOOD_FIELD_MAP_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define LFM_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the trigger is seen, the check must hold on the next clock.
`define LFM_ASSERT_NEXT(label, clk, rst, trig, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error(msg);

// When the trigger is seen, the check must hold in the same clock.
`define LFM_ASSERT_SAME(label, clk, rst, trig, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
      else $error(msg);

`endif

@@ rtl/core/lfm_pkg.sv @@
// Shared constants, codes and payload types of the likelihood field map.
package lfm_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_DIST    = 6;
   localparam int WIN         = 2 * MAX_DIST + 1;
   localparam int HIST_W      = 2 * MAX_DIST;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 11;
   localparam int DIM_W       = 11;
   localparam int OUT_W       = 10;
   localparam int LEVEL_W     = 8;
   localparam int TABLE_W     = 56;
   localparam int DIST_W      = $clog2(MAX_DIST + 2);
   localparam int POS_W       = 21;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;

   localparam logic [DIST_W-1:0]  NO_DIST      = DIST_W'(MAX_DIST + 1);
   localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(700);
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(500);
   localparam logic [TABLE_W-1:0] TABLE_RESET  = TABLE_W'(562);

   typedef enum logic {
      REQ_CELL  = 1'b0,
      REQ_DRAIN = 1'b1
   } lfm_req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH   = 2'd0,
      CSR_MAP_HEIGHT  = 2'd1,
      CSR_LEVEL_TABLE = 2'd2
   } lfm_csr_index_type;

   typedef struct packed {
      lfm_req_kind_type req_type;
      logic             occupied;
   } lfm_req_type;

   typedef struct packed {
      logic [OUT_W-1:0]   col_x;
      logic [OUT_W-1:0]   row_y;
      logic [LEVEL_W-1:0] level;
      logic               last;
   } lfm_rsp_type;

   // Effective map width after clamping, plus the level bytes.
   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [TABLE_W-1:0] level_table;
   } lfm_cfg_type;

   // One classified cell on its way from the front to the back pipeline.
   typedef struct packed {
      logic             occ_bit;
      logic [COL_W-1:0] in_col;
      logic [ROW_W-1:0] in_row;
      logic             has_out;
      logic [COL_W-1:0] out_col;
      logic [OUT_W-1:0] out_row;
      logic             last;
   } lfm_item_type;

endpackage

@@ rtl/core/likelihood_field_map.sv @@
// Top level of the likelihood field map: front end, queue and back pipeline.
//
// channel | handshake             | beat contents
// req     | req_valid / req_ready | lfm_req_type: req_type, occupied
// rsp     | rsp_valid / rsp_ready | lfm_rsp_type: col_x, row_y, level, last
// csr     | csr_valid / csr_ready | csr_index, csr_data; always ready
//
// Sustained rate is one cell per clock while rsp is not held, set by the column history
// RAM, which takes one read and one write per clock; the read of one cell overlaps the
// write of the previous one through forwarding.
// A cell's result is offered on rsp once the beat that completes its window, six rows
// plus six cells later in the raster stream, has passed the queue and the back pipeline.
// Reset is synchronous; it clears counters, queue and pipeline valids and loads the
// register defaults. The history RAM is not swept, so no clearing pass is needed.
// A held rsp beat freezes the back pipeline; the four-entry queue then takes up to four
// more req beats before req_ready drops.
module likelihood_field_map (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lfm_pkg::lfm_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lfm_pkg::lfm_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [55:0]          csr_data
);
   import lfm_pkg::*;

   logic         push_valid, push_ready;
   lfm_item_type push_item;
   logic         pop_valid, pop_ready;
   lfm_item_type pop_item;
   lfm_cfg_type  cfg;

   lfm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .cfg        (cfg)
   );

   lfm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   lfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/lfm_front.sv @@
// Front end: register file, raster counters and classification of each beat.
module lfm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lfm_pkg::lfm_req_type       req_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [55:0]                csr_data,
   output logic                       push_valid,
   input  logic                       push_ready,
   output lfm_pkg::lfm_item_type      push_item,
   output lfm_pkg::lfm_cfg_type       cfg
);
   import lfm_pkg::*;

   logic [DIM_W-1:0]   map_width_ff, map_width_in;
   logic [DIM_W-1:0]   map_height_ff, map_height_in;
   logic [TABLE_W-1:0] level_table_ff, level_table_in;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             map_done_ff, map_done_in;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic [POS_W-1:0] lag;
   logic [COL_W-1:0] cur_col, cur_out_col;
   logic [ROW_W-1:0] cur_row, cur_out_row;
   logic [POS_W-1:0] cur_pos;
   logic [DIM_W-1:0] col_inc, out_col_inc;
   logic             skip, push_fire, has_out, fin, occ_bit;

   assign csr_ready = 1'b1;

   always_comb begin
      map_width_in   = map_width_ff;
      map_height_in  = map_height_ff;
      level_table_in = level_table_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAP_WIDTH:   map_width_in   = csr_data[DIM_W-1:0];
            CSR_MAP_HEIGHT:  map_height_in  = csr_data[DIM_W-1:0];
            CSR_LEVEL_TABLE: level_table_in = csr_data[TABLE_W-1:0];
            default:         map_width_in   = map_width_ff;
         endcase
      end
   end

   always_comb begin
      if (map_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (map_width_ff > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = map_width_ff;
      end
      if (map_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (map_height_ff > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = map_height_ff;
      end
   end

   assign cfg.width       = w_eff;
   assign cfg.level_table = level_table_ff;

   // Results start once six rows plus six cells have gone by.
   assign lag = POS_W'(w_eff) * POS_W'(MAX_DIST) + POS_W'(MAX_DIST);

   // A finished map restarts at the origin on the next cell beat.
   assign cur_col     = map_done_ff ? '0 : in_col_ff;
   assign cur_row     = map_done_ff ? '0 : in_row_ff;
   assign cur_out_col = map_done_ff ? '0 : out_col_ff;
   assign cur_out_row = map_done_ff ? '0 : out_row_ff;
   assign cur_pos     = map_done_ff ? '0 : pos_ff;

   assign skip       = map_done_ff && (req_data.req_type == REQ_DRAIN);
   assign req_ready  = push_ready;
   assign push_valid = req_valid && !skip;
   assign push_fire  = push_valid && push_ready;

   assign has_out = (cur_pos >= lag);
   assign fin     = has_out && (cur_out_row >= (h_eff - DIM_W'(1)))
                  && ({1'b0, cur_out_col} >= (w_eff - DIM_W'(1)));
   assign occ_bit = (req_data.req_type == REQ_CELL) && (cur_row < h_eff)
                  && req_data.occupied;

   assign col_inc     = {1'b0, cur_col} + DIM_W'(1);
   assign out_col_inc = {1'b0, cur_out_col} + DIM_W'(1);

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      pos_in      = pos_ff;
      map_done_in = map_done_ff;
      if (push_fire) begin
         pos_in      = cur_pos + POS_W'(1);
         map_done_in = fin;
         if (col_inc >= w_eff) begin
            in_col_in = '0;
            in_row_in = cur_row + ROW_W'(1);
         end else begin
            in_col_in = col_inc[COL_W-1:0];
            in_row_in = cur_row;
         end
         out_col_in = cur_out_col;
         out_row_in = cur_out_row;
         if (has_out && !fin) begin
            if (out_col_inc >= w_eff) begin
               out_col_in = '0;
               out_row_in = cur_out_row + ROW_W'(1);
            end else begin
               out_col_in = out_col_inc[COL_W-1:0];
            end
         end
      end
   end

   assign push_item.occ_bit = occ_bit;
   assign push_item.in_col  = cur_col;
   assign push_item.in_row  = cur_row;
   assign push_item.has_out = has_out;
   assign push_item.out_col = cur_out_col;
   assign push_item.out_row = cur_out_row[OUT_W-1:0];
   assign push_item.last    = fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= WIDTH_RESET;
         map_height_ff  <= HEIGHT_RESET;
         level_table_ff <= TABLE_RESET;
         in_col_ff      <= '0;
         in_row_ff      <= '0;
         out_col_ff     <= '0;
         out_row_ff     <= '0;
         pos_ff         <= '0;
         map_done_ff    <= 1'b0;
      end else begin
         map_width_ff   <= map_width_in;
         map_height_ff  <= map_height_in;
         level_table_ff <= level_table_in;
         in_col_ff      <= in_col_in;
         in_row_ff      <= in_row_in;
         out_col_ff     <= out_col_in;
         out_row_ff     <= out_row_in;
         pos_ff         <= pos_in;
         map_done_ff    <= map_done_in;
      end
   end

endmodule

@@ rtl/core/lfm_queue.sv @@
// Short queue of classified cells between the front end and the back pipeline.
`include "likelihood_field_map_defines.svh"

module lfm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  lfm_pkg::lfm_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output lfm_pkg::lfm_item_type pop_item
);
   import lfm_pkg::*;

   lfm_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LFM_ASSERT_HOLDS(a_queue_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
   `LFM_ASSERT_NEXT(a_queue_grow, clock, reset, push_fire && !pop_fire, count_ff == $past(count_ff) + QCNT_W'(1), "queue count did not grow on push")

endmodule

@@ rtl/core/lfm_back.sv @@
// Back pipeline: column history RAM, vertical distance, horizontal window and level.
`include "likelihood_field_map_defines.svh"

module lfm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  lfm_pkg::lfm_item_type pop_item,
   input  lfm_pkg::lfm_cfg_type  cfg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lfm_pkg::lfm_rsp_type  rsp_data
);
   import lfm_pkg::*;

   // Per column, the twelve rows above the current one, newest in bit 0.
   logic [HIST_W-1:0] hist_mem [MAX_WIDTH];
   logic [HIST_W-1:0] rd_q_ff;
   logic [HIST_W-1:0] fwd_data_ff, fwd_data_in;
   logic              fwd_ff, fwd_in;

   logic              s1_valid_ff, s1_valid_in;
   lfm_item_type      s1_ff;
   logic              s2_valid_ff, s2_valid_in;
   lfm_item_type      s2_ff;
   logic              s3_valid_ff, s3_valid_in;
   lfm_item_type      s3_ff;
   logic [DIST_W-1:0] best_ff;
   logic [DIST_W-1:0] sl_ff [WIN];

   logic              rsp_valid_ff, rsp_valid_in;
   lfm_rsp_type       rsp_data_ff, rsp_data_in;

   logic              en, take, wr;
   logic [HIST_W-1:0] hist_old, hist_new;
   logic [WIN-1:0]    col_bits;
   logic [DIST_W-1:0] vdist;
   logic [WIN-1:0]    tap_ok;
   logic [MAX_DIST:0] hit;
   logic [DIST_W-1:0] best;
   logic [LEVEL_W-1:0] lvl;

   // The whole back pipeline advances only when the result register is free.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop_ready = en;
   assign take      = pop_valid && en;
   assign wr        = en && s1_valid_ff;

   // The previous cell writes its column in the same clock that this cell reads,
   // so a matching column takes the written value instead of the RAM output.
   assign hist_old    = fwd_ff ? fwd_data_ff : rd_q_ff;
   assign hist_new    = {hist_old[HIST_W-2:0], s1_ff.occ_bit};
   assign fwd_in      = take && s1_valid_ff && (s1_ff.in_col == pop_item.in_col);
   assign fwd_data_in = hist_new;

   always_ff @(posedge clock) begin
      if (wr) begin
         hist_mem[s1_ff.in_col] <= hist_new;
      end
      if (take) begin
         rd_q_ff <= hist_mem[pop_item.in_col];
      end
   end

   // Bit j of the column is row in_row - j; rows above the map are dropped.
   always_comb begin
      col_bits = {hist_old, s1_ff.occ_bit};
      for (int j = 0; j < WIN; j++) begin
         if (ROW_W'(j) > s1_ff.in_row) begin
            col_bits[j] = 1'b0;
         end
      end
      vdist = NO_DIST;
      for (int d = MAX_DIST; d >= 0; d--) begin
         if (col_bits[MAX_DIST-d] || col_bits[MAX_DIST+d]) begin
            vdist = DIST_W'(d);
         end
      end
   end

   // Tap k of the shift line is column out_col + MAX_DIST - k of the same row.
   always_comb begin
      for (int k = 0; k < WIN; k++) begin
         if (k <= MAX_DIST) begin
            tap_ok[k] = ({1'b0, s2_ff.out_col} + DIM_W'(MAX_DIST - k)) < cfg.width;
         end else begin
            tap_ok[k] = s2_ff.out_col >= COL_W'(k - MAX_DIST);
         end
      end
      hit = '0;
      for (int d = 0; d <= MAX_DIST; d++) begin
         for (int k = 0; k < WIN; k++) begin
            if ((k >= MAX_DIST - d) && (k <= MAX_DIST + d) && tap_ok[k]
                && (sl_ff[k] <= DIST_W'(d))) begin
               hit[d] = 1'b1;
            end
         end
      end
      best = NO_DIST;
      for (int d = MAX_DIST; d >= 0; d--) begin
         if (hit[d]) begin
            best = DIST_W'(d);
         end
      end
   end

   always_comb begin
      lvl = '0;
      if ((best_ff <= DIST_W'(MAX_DIST)) && (int'(best_ff) < TABLE_W / LEVEL_W)) begin
         lvl = cfg.level_table[LEVEL_W*best_ff +: LEVEL_W];
      end
   end

   assign s1_valid_in = en ? take : s1_valid_ff;
   assign s2_valid_in = en ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = en ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = en ? (s3_valid_ff && s3_ff.has_out) : rsp_valid_ff;

   always_comb begin
      rsp_data_in       = rsp_data_ff;
      if (en) begin
         rsp_data_in.col_x = s3_ff.out_col;
         rsp_data_in.row_y = s3_ff.out_row;
         rsp_data_in.level = lvl;
         rsp_data_in.last  = s3_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff       <= pop_item;
         fwd_data_ff <= fwd_data_in;
         s2_ff       <= s1_ff;
         s3_ff       <= s2_ff;
         best_ff     <= best;
      end
      if (wr) begin
         sl_ff[0] <= vdist;
         for (int k = 1; k < WIN; k++) begin
            sl_ff[k] <= sl_ff[k-1];
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         fwd_ff       <= en ? fwd_in : fwd_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LFM_ASSERT_SAME(a_fwd_needs_cell, clock, reset, fwd_ff, s1_valid_ff, "forwarded history without a cell in the read stage")
   `LFM_ASSERT_NEXT(a_result_loaded, clock, reset, en && s3_valid_ff && s3_ff.has_out, rsp_valid_ff, "reported cell did not reach the result register")
   `LFM_ASSERT_NEXT(a_stall_freezes, clock, reset, rsp_valid_ff && !rsp_ready, $stable(s3_valid_ff) && $stable(best_ff), "back pipeline moved during a stall")

endmodule
